// ===== rtl/ptc_pkg.sv =====
// ----------------------------------------------------------------------------
// ptc_pkg: shared types and constants for pressure/temperature compensation
// Register indexes, widths and the side-band record carried past the divider.
// ----------------------------------------------------------------------------
package ptc_pkg;

    localparam int unsigned RawWidth  = 20;
    localparam int unsigned CfgWidth  = 48;
    localparam int unsigned CoefWidth = 16;
    localparam int unsigned DenWidth  = 31;
    localparam int unsigned NumWidth  = 64;

    typedef enum logic [2:0] {
        REG_TEMP_COEF_ONE    = 3'd0,
        REG_TEMP_COEF_TWO    = 3'd1,
        REG_TEMP_COEF_THREE  = 3'd2,
        REG_PRESS_COEF_ONE   = 3'd3,
        REG_PRESS_COEF_TWO   = 3'd4,
        REG_PRESS_COEF_THREE = 3'd5,
        REG_PRESS_COEFS_4_6  = 3'd6,
        REG_PRESS_COEFS_7_9  = 3'd7
    } cfg_idx_t;

    // temperature results and the zero-divisor flag ride along the divider
    typedef struct packed {
        logic signed [31:0] tcent;
        logic signed [31:0] tfine;
        logic               invalid;
    } side_t;

endpackage

// ===== rtl/ptc_div.sv =====
// ----------------------------------------------------------------------------
// ptc_div: pipelined signed 64 / 31 bit divider
// Truncates toward zero; one quotient bit per stage, one transfer per cycle while en is high.
// ----------------------------------------------------------------------------
module ptc_div (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic signed [63:0]    in_num,
    input  logic signed [30:0]    in_den,
    input  ptc_pkg::side_t        in_side,
    output logic                  out_valid,
    output logic signed [63:0]    out_quot,
    output ptc_pkg::side_t        out_side
);

    logic                              vld_reg  [0:ptc_pkg::NumWidth];
    logic [ptc_pkg::DenWidth-1:0]      rem_reg  [0:ptc_pkg::NumWidth];
    logic [ptc_pkg::NumWidth-1:0]      num_reg  [0:ptc_pkg::NumWidth];
    logic [ptc_pkg::DenWidth-1:0]      den_reg  [0:ptc_pkg::NumWidth];
    logic                              neg_reg  [0:ptc_pkg::NumWidth];
    ptc_pkg::side_t                    side_reg [0:ptc_pkg::NumWidth];

    logic                              fin_vld_reg;
    logic signed [63:0]                fin_quot_reg;
    ptc_pkg::side_t                    fin_side_reg;

    // magnitude prep
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg[0] <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0]  <= '0;
            num_reg[0]  <= in_num[63] ? 64'(-in_num) : 64'(in_num);
            den_reg[0]  <= in_den[30] ? 31'(-in_den) : 31'(in_den);
            neg_reg[0]  <= in_num[63] ^ in_den[30];
            side_reg[0] <= in_side;
        end
    end

    // restoring steps; remainder stays below the divisor so 31 bits suffice
    for (genvar k = 1; k <= ptc_pkg::NumWidth; k++) begin : g_step
        logic [31:0] trial;
        logic        ge;

        always_comb begin
            trial = {rem_reg[k-1], num_reg[k-1][63]};
            ge    = trial >= {1'b0, den_reg[k-1]};
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]  <= ge ? 31'(trial - {1'b0, den_reg[k-1]}) : trial[30:0];
                num_reg[k]  <= {num_reg[k-1][62:0], ge};
                den_reg[k]  <= den_reg[k-1];
                neg_reg[k]  <= neg_reg[k-1];
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    // sign restore
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fin_vld_reg <= 1'b0;
        end else if (en) begin
            fin_vld_reg <= vld_reg[ptc_pkg::NumWidth];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            fin_quot_reg <= neg_reg[ptc_pkg::NumWidth]
                            ? $signed(-num_reg[ptc_pkg::NumWidth])
                            : $signed(num_reg[ptc_pkg::NumWidth]);
            fin_side_reg <= side_reg[ptc_pkg::NumWidth];
        end
    end

    assign out_valid = fin_vld_reg;
    assign out_quot  = fin_quot_reg;
    assign out_side  = fin_side_reg;

endmodule

// ===== rtl/pressure_temperature_compensation_top.sv =====
// ----------------------------------------------------------------------------
// pressure_temperature_compensation_top: barometer sample compensation
// Integer compensation of raw temperature and pressure with twelve
// calibration words, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (s_valid/s_ready) carries one raw temperature and one raw
//   pressure sample per transfer. Result channel (m_valid/m_ready) returns
//   temperature in 0.01 degC, the fine temperature term, pressure in Pa as
//   Q24.8 (low 32 bits) and a flag that is set when the pressure divisor is
//   zero, in which case pressure reads 0.
//   Calibration is loaded through cfg_wr_en/cfg_index/cfg_wdata, one register
//   per cycle, while no transfer is in flight; all registers reset to 0.
//   The pipeline has 81 register stages: 10 arithmetic stages, a 66-stage
//   divider (prep, one quotient bit per stage for 64 bits, sign restore),
//   4 post-divide stages and the output register.
//   Throughput is one transfer per cycle unless the pipeline is frozen; the
//   divider and all multipliers are pipelined.
//   When the receiver holds m_ready low with a result waiting, the whole
//   pipeline freezes and s_ready drops; nothing is lost or repeated.
//   Reset (aresetn low, synchronous) empties the pipeline and clears config.
// ----------------------------------------------------------------------------
module pressure_temperature_compensation_top (
    input  logic                aclk,
    input  logic                aresetn,
    // configuration
    input  logic                cfg_wr_en,
    input  logic [2:0]          cfg_index,
    input  logic [47:0]         cfg_wdata,
    // raw sample channel
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [19:0]         s_raw_temperature,
    input  logic [19:0]         s_raw_pressure,
    // compensated result channel
    output logic                m_valid,
    input  logic                m_ready,
    output logic signed [31:0]  m_temperature_centi,
    output logic signed [31:0]  m_fine_temperature,
    output logic [31:0]         m_pressure_q24_8,
    output logic                m_pressure_invalid
);

    // ---------------- configuration registers ----------------
    logic [15:0] t1_reg, t2_reg, t3_reg, p1_reg, p2_reg, p3_reg;
    logic [47:0] p456_reg, p789_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            t1_reg   <= '0;
            t2_reg   <= '0;
            t3_reg   <= '0;
            p1_reg   <= '0;
            p2_reg   <= '0;
            p3_reg   <= '0;
            p456_reg <= '0;
            p789_reg <= '0;
        end else if (cfg_wr_en) begin
            case (ptc_pkg::cfg_idx_t'(cfg_index))
                ptc_pkg::REG_TEMP_COEF_ONE:    t1_reg   <= cfg_wdata[15:0];
                ptc_pkg::REG_TEMP_COEF_TWO:    t2_reg   <= cfg_wdata[15:0];
                ptc_pkg::REG_TEMP_COEF_THREE:  t3_reg   <= cfg_wdata[15:0];
                ptc_pkg::REG_PRESS_COEF_ONE:   p1_reg   <= cfg_wdata[15:0];
                ptc_pkg::REG_PRESS_COEF_TWO:   p2_reg   <= cfg_wdata[15:0];
                ptc_pkg::REG_PRESS_COEF_THREE: p3_reg   <= cfg_wdata[15:0];
                ptc_pkg::REG_PRESS_COEFS_4_6:  p456_reg <= cfg_wdata;
                ptc_pkg::REG_PRESS_COEFS_7_9:  p789_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // signed views of the calibration words
    logic signed [15:0] t2, t3, p2, p3, p5, p6, p8, p9;
    logic signed [16:0] p1s;
    logic signed [63:0] p4_64, p7_64;

    assign t2    = $signed(t2_reg);
    assign t3    = $signed(t3_reg);
    assign p1s   = $signed({1'b0, p1_reg});
    assign p2    = $signed(p2_reg);
    assign p3    = $signed(p3_reg);
    assign p4_64 = $signed({{48{p456_reg[15]}}, p456_reg[15:0]});
    assign p5    = $signed(p456_reg[31:16]);
    assign p6    = $signed(p456_reg[47:32]);
    assign p7_64 = $signed({{48{p789_reg[15]}}, p789_reg[15:0]});
    assign p8    = $signed(p789_reg[31:16]);
    assign p9    = $signed(p789_reg[47:32]);

    // ---------------- flow control ----------------
    // single pipeline-wide advance; frozen only when the output is held
    logic en;
    logic m_valid_reg;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    logic s1_vld_reg, s2_vld_reg, s3_vld_reg, s4_vld_reg, s5_vld_reg;
    logic s6_vld_reg, s7_vld_reg, s8_vld_reg, s9_vld_reg, s10_vld_reg;
    logic sa_vld_reg, sb_vld_reg, sc_vld_reg, sd_vld_reg;
    logic div_vld;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            s3_vld_reg  <= 1'b0;
            s4_vld_reg  <= 1'b0;
            s5_vld_reg  <= 1'b0;
            s6_vld_reg  <= 1'b0;
            s7_vld_reg  <= 1'b0;
            s8_vld_reg  <= 1'b0;
            s9_vld_reg  <= 1'b0;
            s10_vld_reg <= 1'b0;
            sa_vld_reg  <= 1'b0;
            sb_vld_reg  <= 1'b0;
            sc_vld_reg  <= 1'b0;
            sd_vld_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            s1_vld_reg  <= s_valid;
            s2_vld_reg  <= s1_vld_reg;
            s3_vld_reg  <= s2_vld_reg;
            s4_vld_reg  <= s3_vld_reg;
            s5_vld_reg  <= s4_vld_reg;
            s6_vld_reg  <= s5_vld_reg;
            s7_vld_reg  <= s6_vld_reg;
            s8_vld_reg  <= s7_vld_reg;
            s9_vld_reg  <= s8_vld_reg;
            s10_vld_reg <= s9_vld_reg;
            sa_vld_reg  <= div_vld;
            sb_vld_reg  <= sa_vld_reg;
            sc_vld_reg  <= sb_vld_reg;
            sd_vld_reg  <= sc_vld_reg;
            m_valid_reg <= sd_vld_reg;
        end
    end

    // ---------------- temperature path (32-bit wrap) ----------------
    logic signed [17:0] s1_a_reg, s1_b_reg;
    logic [19:0]        s1_adcp_reg;

    logic signed [31:0] s2_tv1_reg, s2_bq_reg;
    logic [19:0]        s2_adcp_reg;

    logic signed [31:0] s3_tv1_reg, s3_tv2_reg;
    logic [19:0]        s3_adcp_reg;

    logic signed [31:0] s4_tfine_reg;
    logic [19:0]        s4_adcp_reg;

    logic signed [31:0] s5_tfine_reg, s5_tcent_reg;
    logic signed [32:0] s5_v1_reg;
    logic [19:0]        s5_adcp_reg;

    logic signed [31:0] mul_a, mul_b, mul_c, mul_d;

    always_comb begin
        mul_a = s1_a_reg * t2;
        mul_b = s1_b_reg * s1_b_reg;
        mul_c = s2_bq_reg * t3;
        mul_d = s4_tfine_reg * 32'sd5 + 32'sd128;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            // stage 1: offsets against word one
            s1_a_reg    <= $signed(18'({1'b0, s_raw_temperature[19:3]})
                                 - 18'({1'b0, t1_reg, 1'b0}));
            s1_b_reg    <= $signed(18'({2'b0, s_raw_temperature[19:4]})
                                 - 18'({2'b0, t1_reg}));
            s1_adcp_reg <= s_raw_pressure;
            // stage 2: linear term and square
            s2_tv1_reg  <= mul_a >>> 11;
            s2_bq_reg   <= mul_b >>> 12;
            s2_adcp_reg <= s1_adcp_reg;
            // stage 3: quadratic term
            s3_tv1_reg  <= s2_tv1_reg;
            s3_tv2_reg  <= mul_c >>> 14;
            s3_adcp_reg <= s2_adcp_reg;
            // stage 4: fine temperature
            s4_tfine_reg <= s3_tv1_reg + s3_tv2_reg;
            s4_adcp_reg  <= s3_adcp_reg;
            // stage 5: centi-degrees and pressure offset
            s5_tfine_reg <= s4_tfine_reg;
            s5_tcent_reg <= mul_d >>> 8;
            s5_v1_reg    <= s4_tfine_reg - 33'sd128000;
            s5_adcp_reg  <= s4_adcp_reg;
        end
    end

    // ---------------- pressure path, pre-divide (64-bit wrap) ----------------
    logic signed [63:0] s6_sq_reg, s6_v1p5_reg, s6_v1p2_reg;
    logic signed [63:0] s7_v2a_reg, s7_v1a_reg, s7_v1p5_reg, s7_v1p2_reg;
    logic signed [63:0] s8_v2_reg, s8_v1b_reg;
    logic signed [63:0] s9_n0_reg, s9_dprod_reg;
    logic signed [63:0] s10_num_reg;
    logic signed [30:0] s10_den_reg;
    logic [19:0]        s6_adcp_reg, s7_adcp_reg, s8_adcp_reg;
    ptc_pkg::side_t     s6_side_reg, s7_side_reg, s8_side_reg, s9_side_reg;
    ptc_pkg::side_t     s10_side_reg;

    logic signed [63:0] sq_n, v1p5_n, v1p2_n, v2a_n, v1a_n, dprod_n, num_n;
    logic [20:0]        pp;
    logic signed [63:0] pp64;

    always_comb begin
        sq_n    = s5_v1_reg * s5_v1_reg;
        v1p5_n  = s5_v1_reg * p5;
        v1p2_n  = s5_v1_reg * p2;
        v2a_n   = s6_sq_reg * p6;
        v1a_n   = s6_sq_reg * p3;
        dprod_n = (s8_v1b_reg + 64'sh0000_8000_0000_0000) * p1s;
        pp      = 21'd1048576 - {1'b0, s8_adcp_reg};
        pp64    = $signed({43'd0, pp});
        num_n   = s9_n0_reg * 64'sd3125;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            // stage 6: square and linear products of the offset
            s6_sq_reg         <= sq_n;
            s6_v1p5_reg       <= v1p5_n;
            s6_v1p2_reg       <= v1p2_n;
            s6_adcp_reg       <= s5_adcp_reg;
            s6_side_reg.tcent <= s5_tcent_reg;
            s6_side_reg.tfine <= s5_tfine_reg;
            s6_side_reg.invalid <= 1'b0;
            // stage 7: square times words six and three
            s7_v2a_reg  <= v2a_n;
            s7_v1a_reg  <= v1a_n;
            s7_v1p5_reg <= s6_v1p5_reg;
            s7_v1p2_reg <= s6_v1p2_reg;
            s7_adcp_reg <= s6_adcp_reg;
            s7_side_reg <= s6_side_reg;
            // stage 8: sum the offset polynomials
            s8_v2_reg   <= s7_v2a_reg + (s7_v1p5_reg <<< 17) + (p4_64 <<< 35);
            s8_v1b_reg  <= (s7_v1a_reg >>> 8) + (s7_v1p2_reg <<< 12);
            s8_adcp_reg <= s7_adcp_reg;
            s8_side_reg <= s7_side_reg;
            // stage 9: divisor scale, dividend base
            s9_dprod_reg <= dprod_n;
            s9_n0_reg    <= (pp64 <<< 31) - s8_v2_reg;
            s9_side_reg  <= s8_side_reg;
            // stage 10: final dividend and divisor, zero check
            s10_num_reg  <= num_n;
            s10_den_reg  <= s9_dprod_reg[63:33];
            s10_side_reg.tcent   <= s9_side_reg.tcent;
            s10_side_reg.tfine   <= s9_side_reg.tfine;
            s10_side_reg.invalid <= (s9_dprod_reg[63:33] == 31'd0);
        end
    end

    // ---------------- divider ----------------
    logic signed [63:0] div_quot;
    ptc_pkg::side_t     div_side;

    ptc_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s10_vld_reg),
        .in_num    (s10_num_reg),
        .in_den    (s10_den_reg),
        .in_side   (s10_side_reg),
        .out_valid (div_vld),
        .out_quot  (div_quot),
        .out_side  (div_side)
    );

    // ---------------- pressure path, post-divide ----------------
    // (q>>13)^2 mod 2^64 split into 32-bit halves: lo*lo + 2*hi*lo<<32
    logic signed [63:0] sa_q_reg, sa_p8p_reg;
    logic [63:0]        sa_m0_reg;
    logic [31:0]        sa_m1_reg;
    ptc_pkg::side_t     sa_side_reg;

    logic signed [63:0] sb_q_reg, sb_sq_reg, sb_v2p_reg;
    ptc_pkg::side_t     sb_side_reg;

    logic signed [63:0] sc_q_reg, sc_t9_reg, sc_v2p_reg;
    ptc_pkg::side_t     sc_side_reg;

    logic signed [63:0] sd_s_reg;
    ptc_pkg::side_t     sd_side_reg;

    logic signed [63:0] xq, p8p_n, t9_n, pres_n;
    logic [63:0]        m0_n;
    logic [31:0]        m1_n;

    always_comb begin
        xq     = div_quot >>> 13;
        m0_n   = xq[31:0] * xq[31:0];
        m1_n   = xq[63:32] * xq[31:0];
        p8p_n  = div_quot * p8;
        t9_n   = sb_sq_reg * p9;
        pres_n = (sd_s_reg >>> 8) + (p7_64 <<< 4);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sa_q_reg    <= div_quot;
            sa_m0_reg   <= m0_n;
            sa_m1_reg   <= m1_n;
            sa_p8p_reg  <= p8p_n;
            sa_side_reg <= div_side;

            sb_q_reg    <= sa_q_reg;
            sb_sq_reg   <= $signed(sa_m0_reg + {sa_m1_reg[30:0], 33'd0});
            sb_v2p_reg  <= sa_p8p_reg >>> 19;
            sb_side_reg <= sa_side_reg;

            sc_q_reg    <= sb_q_reg;
            sc_t9_reg   <= t9_n;
            sc_v2p_reg  <= sb_v2p_reg;
            sc_side_reg <= sb_side_reg;

            sd_s_reg    <= sc_q_reg + (sc_t9_reg >>> 25) + sc_v2p_reg;
            sd_side_reg <= sc_side_reg;
        end
    end

    // ---------------- output register ----------------
    logic signed [31:0] m_tcent_reg, m_tfine_reg;
    logic [31:0]        m_pres_reg;
    logic               m_inv_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tcent_reg <= sd_side_reg.tcent;
            m_tfine_reg <= sd_side_reg.tfine;
            m_pres_reg  <= sd_side_reg.invalid ? 32'd0 : pres_n[31:0];
            m_inv_reg   <= sd_side_reg.invalid;
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_temperature_centi = m_tcent_reg;
    assign m_fine_temperature  = m_tfine_reg;
    assign m_pressure_q24_8    = m_pres_reg;
    assign m_pressure_invalid  = m_inv_reg;

endmodule
